/* rtl/lcc_pkg.sv */
// Shared types, codes and constants of the Lloyd coverage centroid core.
// No dependencies; every other rtl file but lcc_checker imports this package.
`default_nettype none
package lcc_pkg;

   localparam int MAX_ROBOTS         = 16;
   localparam int MAX_BLOBS          = 4;
   localparam int MAX_CELLS_PER_SIDE = 64;
   localparam int EXP_TABLE_DEPTH    = 256;
   localparam int EXP_RATIO          = 61565;

   localparam int ROBOT_W = $clog2(MAX_ROBOTS);
   localparam int BLOB_W  = $clog2(MAX_BLOBS);
   localparam int CELL_W  = $clog2(MAX_CELLS_PER_SIDE);
   localparam int EXP_W   = $clog2(EXP_TABLE_DEPTH);
   localparam int CSR_W   = 32;

   // input commands
   localparam logic [1:0] CMD_LOAD_ROBOT = 2'd0;
   localparam logic [1:0] CMD_LOAD_BLOB  = 2'd1;
   localparam logic [1:0] CMD_RUN        = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_ROBOT_COUNT    = 3'd0;
   localparam logic [2:0] CSR_TARGET_COUNT   = 3'd1;
   localparam logic [2:0] CSR_DOMAIN_START   = 3'd2;
   localparam logic [2:0] CSR_CELL_WIDTH     = 3'd3;
   localparam logic [2:0] CSR_CELLS_PER_SIDE = 3'd4;
   localparam logic [2:0] CSR_INV_TWO_SIGMA  = 3'd5;
   localparam logic [2:0] CSR_MASS_THRESHOLD = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CELL, ST_R_ABS, ST_R_SQ, ST_R_CMP, ST_B_ABS, ST_B_SQ, ST_B_IDX,
      ST_B_DENS, ST_MASS, ST_MOM, ST_ACC, ST_OUT_INIT, ST_OUT_CHK, ST_DIV_WAIT,
      ST_OUT_SEND
   } lcc_state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_ACCEPT, OP_CELL, OP_RABS, OP_BABS, OP_SQ, OP_RCMP, OP_BIDX,
      OP_BDENS, OP_MASS, OP_MOM, OP_ACC, OP_OUT_INIT, OP_OUT_CHK, OP_OUT_DIV,
      OP_OUT_NEXT
   } lcc_op_type;

   typedef struct packed {
      lcc_op_type op;
   } lcc_cmd_type;

   typedef struct packed {
      logic run_go;
      logic cells_zero;
      logic r_last;
      logic b_none;
      logic k_last;
      logic grid_last;
      logic held_now;
      logic div_done;
   } lcc_status_type;

   typedef logic [EXP_TABLE_DEPTH-1:0][16:0] exp_table_type;

   // exp(-t/16) in Q1.16, built by repeated rounded scaling
   function automatic exp_table_type build_exp_table();
      exp_table_type t;
      logic [32:0]   p;
      t[0] = 17'd65536;
      for (int i = 1; i < EXP_TABLE_DEPTH; i++) begin
         p    = 33'(t[i-1]) * 33'(EXP_RATIO) + 33'd32768;
         t[i] = p[32:16];
      end
      return t;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp_table();

endpackage
`default_nettype wire

/* rtl/lcc_div.sv */
// Iterative signed-by-unsigned divider, one quotient bit a cycle, result clamped to 16 bits.
// Depends on lcc_pkg.
`default_nettype none
module lcc_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] dividend,
   input  wire logic        [47:0] divisor,
   output logic                    done,
   output logic signed [15:0]      quotient
);
   import lcc_pkg::*;

   logic        busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [5:0]  count_ff, count_in;
   logic [47:0] rem_ff, rem_in, div_ff, div_in;
   logic [63:0] quo_ff, quo_in;
   logic [48:0] shift;
   logic        ge;

   // one restoring step
   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      shift    = {rem_ff, quo_ff[63]};
      ge       = shift >= {1'b0, div_ff};
      if (start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         neg_in   = dividend[63];
         count_in = '0;
         rem_in   = '0;
         div_in   = divisor;
         quo_in   = dividend[63] ? 64'(-dividend) : 64'(dividend);
      end else if (busy_ff) begin
         rem_in   = ge ? 48'(shift - {1'b0, div_ff}) : shift[47:0];
         quo_in   = {quo_ff[62:0], ge};
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff   <= neg_in;
      count_ff <= count_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      quo_ff   <= quo_in;
   end

   // clamp magnitude and apply sign
   always_comb begin
      if (neg_ff) begin
         if ((|quo_ff[63:16]) || (quo_ff[15:0] > 16'd32768)) quotient = 16'sh8000;
         else quotient = signed'(16'(-quo_ff[15:0]));
      end else begin
         if (|quo_ff[63:15]) quotient = 16'sh7FFF;
         else quotient = signed'(quo_ff[15:0]);
      end
   end

   assign done = done_ff;

endmodule
`default_nettype wire

/* rtl/lcc_ctrl.sv */
// Sequencer of the coverage step: grid walk, robot and blob passes, output loop.
// Depends on lcc_pkg.
`default_nettype none
module lcc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire lcc_pkg::lcc_status_type status,
   output lcc_pkg::lcc_cmd_type         cmd
);
   import lcc_pkg::*;

   lcc_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (req_valid && status.run_go)
               state_in = status.cells_zero ? ST_OUT_INIT : ST_CELL;
         ST_CELL:   state_in = ST_R_ABS;
         ST_R_ABS:  state_in = ST_R_SQ;
         ST_R_SQ:   state_in = ST_R_CMP;
         ST_R_CMP:
            if (status.r_last) state_in = status.b_none ? ST_MASS : ST_B_ABS;
            else state_in = ST_R_ABS;
         ST_B_ABS:  state_in = ST_B_SQ;
         ST_B_SQ:   state_in = ST_B_IDX;
         ST_B_IDX:  state_in = ST_B_DENS;
         ST_B_DENS: state_in = status.k_last ? ST_MASS : ST_B_ABS;
         ST_MASS:   state_in = ST_MOM;
         ST_MOM:    state_in = ST_ACC;
         ST_ACC:    state_in = status.grid_last ? ST_OUT_INIT : ST_CELL;
         ST_OUT_INIT: state_in = ST_OUT_CHK;
         ST_OUT_CHK:  state_in = status.held_now ? ST_OUT_SEND : ST_DIV_WAIT;
         ST_DIV_WAIT: if (status.div_done) state_in = ST_OUT_SEND;
         ST_OUT_SEND:
            if (rsp_ready) state_in = status.r_last ? ST_IDLE : ST_OUT_CHK;
         default:   state_in = ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd.op = OP_NONE;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) cmd.op = OP_ACCEPT;
         ST_CELL:     cmd.op = OP_CELL;
         ST_R_ABS:    cmd.op = OP_RABS;
         ST_R_SQ:     cmd.op = OP_SQ;
         ST_R_CMP:    cmd.op = OP_RCMP;
         ST_B_ABS:    cmd.op = OP_BABS;
         ST_B_SQ:     cmd.op = OP_SQ;
         ST_B_IDX:    cmd.op = OP_BIDX;
         ST_B_DENS:   cmd.op = OP_BDENS;
         ST_MASS:     cmd.op = OP_MASS;
         ST_MOM:      cmd.op = OP_MOM;
         ST_ACC:      cmd.op = OP_ACC;
         ST_OUT_INIT: cmd.op = OP_OUT_INIT;
         ST_OUT_CHK:  cmd.op = OP_OUT_CHK;
         ST_DIV_WAIT: if (status.div_done) cmd.op = OP_OUT_DIV;
         ST_OUT_SEND: if (rsp_ready) cmd.op = OP_OUT_NEXT;
         default:     cmd.op = OP_NONE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT_SEND);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule
`default_nettype wire

/* rtl/lcc_dp.sv */
// Datapath: configuration, robot and blob stores, distance, density and moment arithmetic.
// Depends on lcc_pkg and lcc_div.
`default_nettype none
module lcc_dp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lcc_pkg::lcc_cmd_type    cmd,
   output lcc_pkg::lcc_status_type      status,
   input  wire logic                    csr_write_enable,
   input  wire logic [2:0]              csr_index,
   input  wire logic [31:0]             csr_write_data,
   input  wire logic [1:0]              req_command,
   input  wire logic [3:0]              req_slot,
   input  wire logic signed [15:0]      req_pos_x,
   input  wire logic signed [15:0]      req_pos_y,
   input  wire logic [15:0]             req_blob_weight,
   output logic [3:0]                   rsp_robot_index,
   output logic signed [15:0]           rsp_centroid_x,
   output logic signed [15:0]           rsp_centroid_y,
   output logic                         rsp_held,
   output logic                         rsp_last
);
   import lcc_pkg::*;

   // configuration
   logic [4:0]         robot_count_ff;
   logic [2:0]         target_count_ff;
   logic signed [15:0] domain_start_ff;
   logic [15:0]        cell_width_ff, inv_ff;
   logic [6:0]         cells_per_side_ff;
   logic [31:0]        threshold_ff;

   // stores
   logic signed [15:0] robot_x_ff [MAX_ROBOTS];
   logic signed [15:0] robot_y_ff [MAX_ROBOTS];
   logic [MAX_ROBOTS-1:0] seen_ff;
   logic signed [15:0] blob_x_ff [MAX_BLOBS];
   logic signed [15:0] blob_y_ff [MAX_BLOBS];
   logic [15:0]        blob_w_ff [MAX_BLOBS];
   logic signed [63:0] moment_x_ff [MAX_ROBOTS];
   logic signed [63:0] moment_y_ff [MAX_ROBOTS];
   logic [47:0]        mass_ff [MAX_ROBOTS];

   // walk state and working registers
   logic [ROBOT_W-1:0] r_ff, best_ff;
   logic [BLOB_W-1:0]  k_ff;
   logic [CELL_W-1:0]  gi_ff, gj_ff;
   logic signed [24:0] gx_ff, gy_ff;
   logic [31:0]        area_ff;
   logic [23:0]        adx_ff, ady_ff;
   logic [47:0]        sqx_ff, sqy_ff;
   logic [48:0]        best_d2_ff;
   logic [62:0]        prod_ff;
   logic               far_ff;
   logic [17:0]        dens_ff;
   logic [33:0]        m_ff;
   logic signed [59:0] px_ff, py_ff;

   logic [4:0]         n_eff;
   logic [2:0]         nb_eff;
   logic [6:0]         cells_eff;
   logic [MAX_ROBOTS-1:0] part_mask;
   logic               run_ok;
   logic signed [24:0] gbase;
   logic signed [15:0] tx, ty;
   logic signed [24:0] dx, dy;
   logic [48:0]        d2;
   logic [16:0]        entry;
   logic [32:0]        wprod;
   logic [49:0]        mprod;
   logic signed [64:0] sum_x, sum_y;
   logic [48:0]        sum_m;
   logic               r_last, k_last, j_last, i_last, held_now;
   logic               div_start, done_x, done_y;
   logic signed [15:0] q_x, q_y;

   // clipped counts and run admission
   always_comb begin
      n_eff     = (robot_count_ff > 5'(MAX_ROBOTS)) ? 5'(MAX_ROBOTS) : robot_count_ff;
      nb_eff    = (target_count_ff > 3'(MAX_BLOBS)) ? 3'(MAX_BLOBS) : target_count_ff;
      cells_eff = (cells_per_side_ff > 7'(MAX_CELLS_PER_SIDE)) ?
                  7'(MAX_CELLS_PER_SIDE) : cells_per_side_ff;
      for (int i = 0; i < MAX_ROBOTS; i++) part_mask[i] = (5'(i) < n_eff);
      run_ok = (n_eff != 5'd0) && (&(seen_ff | ~part_mask));
   end

   assign gbase = 25'(domain_start_ff) + 25'(cell_width_ff[15:1]);

   // distance to a robot or a blob
   always_comb begin
      if (cmd.op == OP_BABS) begin
         tx = blob_x_ff[k_ff];
         ty = blob_y_ff[k_ff];
      end else begin
         tx = robot_x_ff[r_ff];
         ty = robot_y_ff[r_ff];
      end
      dx = gx_ff - 25'(tx);
      dy = gy_ff - 25'(ty);
   end

   assign d2 = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // exp lookup, zero when the argument is off the table
   always_comb begin
      if (far_ff || (|prod_ff[62:28])) entry = '0;
      else entry = EXP_TABLE[prod_ff[EXP_W+19:20]];
      wprod = 33'(blob_w_ff[k_ff]) * 33'(entry);
      mprod = 50'(dens_ff) * 50'(area_ff);
   end

   // saturating accumulation into the winning robot
   always_comb begin
      sum_x = 65'(moment_x_ff[best_ff]) + 65'(px_ff);
      sum_y = 65'(moment_y_ff[best_ff]) + 65'(py_ff);
      sum_m = {1'b0, mass_ff[best_ff]} + 49'(m_ff);
   end

   always_comb begin
      r_last   = (5'(r_ff) + 5'd1 == n_eff);
      k_last   = (3'(k_ff) + 3'd1 == nb_eff);
      j_last   = (7'(gj_ff) + 7'd1 == cells_eff);
      i_last   = (7'(gi_ff) + 7'd1 == cells_eff);
      held_now = (mass_ff[r_ff] <= {16'd0, threshold_ff});
   end

   assign status.run_go     = (req_command == CMD_RUN) && run_ok;
   assign status.cells_zero = (cells_eff == 7'd0);
   assign status.r_last     = r_last;
   assign status.b_none     = (nb_eff == 3'd0);
   assign status.k_last     = k_last;
   assign status.grid_last  = i_last && j_last;
   assign status.held_now   = held_now;
   assign status.div_done   = done_x && done_y;

   assign div_start = (cmd.op == OP_OUT_CHK) && !held_now;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         robot_count_ff    <= 5'd3;
         target_count_ff   <= 3'd2;
         domain_start_ff   <= -16'sd1536;
         cell_width_ff     <= 16'd77;
         cells_per_side_ff <= 7'd40;
         inv_ff            <= 16'd57;
         threshold_ff      <= 32'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROBOT_COUNT:    robot_count_ff    <= csr_write_data[4:0];
            CSR_TARGET_COUNT:   target_count_ff   <= csr_write_data[2:0];
            CSR_DOMAIN_START:   domain_start_ff   <= signed'(csr_write_data[15:0]);
            CSR_CELL_WIDTH:     cell_width_ff     <= csr_write_data[15:0];
            CSR_CELLS_PER_SIDE: cells_per_side_ff <= csr_write_data[6:0];
            CSR_INV_TWO_SIGMA:  inv_ff            <= csr_write_data[15:0];
            CSR_MASS_THRESHOLD: threshold_ff      <= csr_write_data;
            default: ;
         endcase
      end
   end

   // robot and blob loads
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         for (int i = 0; i < MAX_BLOBS; i++) begin
            blob_x_ff[i] <= '0;
            blob_y_ff[i] <= '0;
            blob_w_ff[i] <= '0;
         end
      end else if (cmd.op == OP_ACCEPT) begin
         if (req_command == CMD_LOAD_ROBOT) begin
            seen_ff[req_slot[ROBOT_W-1:0]] <= 1'b1;
         end
         if ((req_command == CMD_LOAD_BLOB) && (32'(req_slot) < MAX_BLOBS)) begin
            blob_x_ff[req_slot[BLOB_W-1:0]] <= req_pos_x;
            blob_y_ff[req_slot[BLOB_W-1:0]] <= req_pos_y;
            blob_w_ff[req_slot[BLOB_W-1:0]] <= req_blob_weight;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == OP_ACCEPT) && (req_command == CMD_LOAD_ROBOT)) begin
         robot_x_ff[req_slot[ROBOT_W-1:0]] <= req_pos_x;
         robot_y_ff[req_slot[ROBOT_W-1:0]] <= req_pos_y;
      end
   end

   // grid walk and accumulation
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_ACCEPT: begin
            if (status.run_go) begin
               for (int i = 0; i < MAX_ROBOTS; i++) begin
                  moment_x_ff[i] <= '0;
                  moment_y_ff[i] <= '0;
                  mass_ff[i]     <= '0;
               end
               gi_ff   <= '0;
               gj_ff   <= '0;
               gx_ff   <= gbase;
               gy_ff   <= gbase;
               area_ff <= 32'(cell_width_ff) * 32'(cell_width_ff);
            end
         end
         OP_CELL: begin
            r_ff    <= '0;
            k_ff    <= '0;
            dens_ff <= '0;
         end
         OP_RABS, OP_BABS: begin
            adx_ff <= dx[24] ? 24'(-dx) : 24'(dx);
            ady_ff <= dy[24] ? 24'(-dy) : 24'(dy);
         end
         OP_SQ: begin
            sqx_ff <= 48'(adx_ff) * 48'(adx_ff);
            sqy_ff <= 48'(ady_ff) * 48'(ady_ff);
         end
         OP_RCMP: begin
            if ((r_ff == '0) || (d2 < best_d2_ff)) begin
               best_d2_ff <= d2;
               best_ff    <= r_ff;
            end
            if (!r_last) r_ff <= r_ff + 1'b1;
         end
         OP_BIDX: begin
            prod_ff <= 63'(d2[46:0]) * 63'(inv_ff);
            far_ff  <= |d2[48:47];
         end
         OP_BDENS: begin
            dens_ff <= dens_ff + 18'(wprod[32:16]);
            if (!k_last) k_ff <= k_ff + 1'b1;
         end
         OP_MASS: m_ff <= mprod[49:16];
         OP_MOM: begin
            px_ff <= gx_ff * signed'({1'b0, m_ff});
            py_ff <= gy_ff * signed'({1'b0, m_ff});
         end
         OP_ACC: begin
            if (sum_x[64] != sum_x[63])
               moment_x_ff[best_ff] <= sum_x[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else moment_x_ff[best_ff] <= sum_x[63:0];
            if (sum_y[64] != sum_y[63])
               moment_y_ff[best_ff] <= sum_y[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else moment_y_ff[best_ff] <= sum_y[63:0];
            mass_ff[best_ff] <= sum_m[48] ? {48{1'b1}} : sum_m[47:0];
            if (j_last) begin
               gj_ff <= '0;
               gy_ff <= gbase;
               gi_ff <= gi_ff + 1'b1;
               gx_ff <= gx_ff + 25'(cell_width_ff);
            end else begin
               gj_ff <= gj_ff + 1'b1;
               gy_ff <= gy_ff + 25'(cell_width_ff);
            end
         end
         OP_OUT_INIT: r_ff <= '0;
         OP_OUT_CHK: begin
            if (held_now) begin
               rsp_robot_index <= 4'(r_ff);
               rsp_centroid_x  <= robot_x_ff[r_ff];
               rsp_centroid_y  <= robot_y_ff[r_ff];
               rsp_held        <= 1'b1;
               rsp_last        <= r_last;
            end
         end
         OP_OUT_DIV: begin
            rsp_robot_index <= 4'(r_ff);
            rsp_centroid_x  <= q_x;
            rsp_centroid_y  <= q_y;
            rsp_held        <= 1'b0;
            rsp_last        <= r_last;
         end
         OP_OUT_NEXT: if (!r_last) r_ff <= r_ff + 1'b1;
         default: ;
      endcase
   end

   lcc_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (moment_x_ff[r_ff]),
      .divisor  (mass_ff[r_ff]),
      .done     (done_x),
      .quotient (q_x)
   );

   lcc_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (moment_y_ff[r_ff]),
      .divisor  (mass_ff[r_ff]),
      .done     (done_y),
      .quotient (q_y)
   );

endmodule
`default_nettype wire

/* rtl/lloyd_coverage_centroid_core.sv */
// Top level of the Lloyd coverage centroid core: controller plus datapath.
// Depends on lcc_pkg, lcc_ctrl, lcc_dp.
//
//   channel | direction | handshake                  | payload
//   req     | in        | req_valid / req_ready      | command, slot, pos_x, pos_y, blob_weight
//   rsp     | out       | rsp_valid / rsp_ready      | robot_index, centroid_x/y, held, last
//   csr     | in        | csr_write_enable           | csr_index, csr_write_data
//
// A run first walks the grid, its pace set by the single shared distance/square unit
// visiting each robot and blob per cell, then serves each robot directly when held or
// through the 64-step divider, plus the wait for rsp_ready. Synchronous reset returns
// to idle with defaults. The core takes a new word only when idle; a stalled result
// word holds the whole run.
`default_nettype none
module lloyd_coverage_centroid_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_command,
   input  wire logic [3:0]         req_slot,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic [15:0]        req_blob_weight,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [3:0]              rsp_robot_index,
   output logic signed [15:0]      rsp_centroid_x,
   output logic signed [15:0]      rsp_centroid_y,
   output logic                    rsp_held,
   output logic                    rsp_last,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_write_data
);
   import lcc_pkg::*;

   lcc_cmd_type    cmd;
   lcc_status_type status;

   lcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lcc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_command      (req_command),
      .req_slot         (req_slot),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_blob_weight  (req_blob_weight),
      .rsp_robot_index  (rsp_robot_index),
      .rsp_centroid_x   (rsp_centroid_x),
      .rsp_centroid_y   (rsp_centroid_y),
      .rsp_held         (rsp_held),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

/* rtl/lcc_checker.sv */
// Port-level checks of the core over time, bound onto the top level.
// Depends on lloyd_coverage_centroid_core.
`default_nettype none
module lcc_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [15:0] rsp_centroid_x,
   input wire logic               rsp_last
);

   // a stalled result word stays valid and keeps its centroid_x
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_centroid_x))
      else $error("result word changed while stalled");

   // no input taken while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready during result delivery");

   // the final word of a run ends it
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid && req_ready)
      else $error("run did not end after last word");

   // a word that is not last keeps the run going
   a_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("run ended before last word");

endmodule

bind lloyd_coverage_centroid_core lcc_checker u_lcc_checker (.*);
`default_nettype wire
